FILE: design/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants of the byte pattern search
// Payload structs, configuration register map and internal step record.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int unsigned MAX_PATTERN = 16;
	localparam int unsigned PAT_BYTES   = 16;
	localparam int unsigned LEN_W       = 5;
	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned CFG_IDX_W   = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_PATTERN_LOW    = 2'd1,
		REG_PATTERN_HIGH   = 2'd2,
		REG_RANGE_START    = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_start;
		logic [ADDR_W-1:0] match_end;
	} out_item_t;

	typedef struct packed {
		logic [LEN_W-1:0]               pattern_length;
		logic [PAT_BYTES-1:0][7:0]      pattern;
		logic [ADDR_W-1:0]              range_start;
	} cfg_t;

	// per-word decision from the window stage
	typedef struct packed {
		logic              emit;
		logic              found;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] count;
	} step_t;

endpackage

FILE: design/bps_stream_if.sv
// ----------------------------------------------------------------------------
// bps_stream_if: valid/ready word channel
// Carries one payload word per handshake; payload type set per instance.
// ----------------------------------------------------------------------------
interface bps_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/byte_pattern_search.sv
// ----------------------------------------------------------------------------
// byte_pattern_search: first occurrence of a byte pattern in a byte stream
// Bytes of a memory range arrive on "stream", one per word, in address order;
// last_byte marks the end of the range. Results leave on "result".
// On the first full match one word is sent with found=1, match_start and
// match_end (one past the match); further bytes of that range give nothing.
// A range that ends unmatched, or an empty pattern, gives one word with
// found=0 and both addresses at range_start, sent for the last byte.
// The result word is registered and sent in the cycle after its accepted byte;
// one byte is taken every cycle, set by the single window-compare stage, and
// the output register keeps accepting while a result waits only if the sink
// takes it in the same cycle; otherwise stream.ready drops until it does.
// Reset clears configuration, window, byte count and the output valid flag;
// stream.ready stays low in reset until the run flag is set. The user must
// write registers via wr_en/wr_index/wr_data only while idle; the block lacks a check.
// ----------------------------------------------------------------------------
module byte_pattern_search #(
	parameter int unsigned MaxPattern = bps_pkg::MAX_PATTERN
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bps_stream_if.sink                      stream,
	bps_stream_if.source                    result,
	input  logic                            wr_en,
	input  bps_pkg::cfg_index_t             wr_index,
	input  logic [bps_pkg::CFG_DATA_W-1:0]  wr_data
);
	import bps_pkg::*;

	cfg_t      cfg;
	step_t     step;
	logic      accept;
	logic      take_ok;
	out_item_t res_item;

	assign stream.ready = take_ok;
	assign accept       = stream.valid && take_ok;

	bps_config u_config (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	bps_window #(
		.MaxPattern (MaxPattern)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (stream.payload),
		.cfg    (cfg),
		.step   (step)
	);

	bps_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.step      (step),
		.cfg       (cfg),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_item  (res_item),
		.in_ready  (take_ok)
	);

	assign result.payload = res_item;

endmodule

FILE: design/bps_config.sv
// ----------------------------------------------------------------------------
// bps_config: configuration registers
// Write-only register file holding pattern length, pattern bytes and range start.
// ----------------------------------------------------------------------------
module bps_config (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  bps_pkg::cfg_index_t                  wr_index,
	input  logic [bps_pkg::CFG_DATA_W-1:0]       wr_data,
	output bps_pkg::cfg_t                        cfg
);
	import bps_pkg::*;

	logic [LEN_W-1:0]      len_q;
	logic [63:0]           pat_low_q;
	logic [63:0]           pat_high_q;
	logic [ADDR_W-1:0]     start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			pat_low_q  <= '0;
			pat_high_q <= '0;
			start_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PATTERN_LENGTH: len_q      <= wr_data[LEN_W-1:0];
				REG_PATTERN_LOW:    pat_low_q  <= wr_data;
				REG_PATTERN_HIGH:   pat_high_q <= wr_data;
				REG_RANGE_START:    start_q    <= wr_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.pattern_length = len_q;
	assign cfg.pattern        = {pat_high_q, pat_low_q};
	assign cfg.range_start    = start_q;

endmodule

FILE: design/bps_window.sv
// ----------------------------------------------------------------------------
// bps_window: byte window, byte counter and pattern compare
// Shifts bytes into the window until a match; checks the pattern in parallel.
// ----------------------------------------------------------------------------
module bps_window #(
	parameter int unsigned MaxPattern = bps_pkg::MAX_PATTERN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  bps_pkg::in_item_t item,
	input  bps_pkg::cfg_t     cfg,
	output bps_pkg::step_t    step
);
	import bps_pkg::*;

	logic [7:0]        window_q [MaxPattern];
	logic [7:0]        window_nx [MaxPattern];
	logic [ADDR_W-1:0] count_q;
	logic [ADDR_W-1:0] count_nx;
	logic              done_q;
	logic [LEN_W-1:0]  len_eff;
	logic [MaxPattern-1:0] pos_ok;
	logic              hit;

	// pattern length clamped to the window depth
	assign len_eff = (cfg.pattern_length > LEN_W'(MaxPattern)) ?
		LEN_W'(MaxPattern) : cfg.pattern_length;

	always_comb begin
		window_nx[0] = item.data_byte;
		for (int k = 1; k < MaxPattern; k++) begin
			window_nx[k] = window_q[k-1];
		end
	end

	// window entry k (newest at 0) must equal pattern byte len-1-k
	always_comb begin
		for (int k = 0; k < MaxPattern; k++) begin
			pos_ok[k] = (LEN_W'(k) >= len_eff) ||
				(window_nx[k] == cfg.pattern[4'(len_eff - LEN_W'(k) - LEN_W'(1))]);
		end
	end

	assign count_nx = count_q + ADDR_W'(1);
	assign hit      = (len_eff != '0) && (count_nx >= ADDR_W'(len_eff)) && (&pos_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MaxPattern; k++) window_q[k] <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			if (item.last_byte) begin
				for (int k = 0; k < MaxPattern; k++) window_q[k] <= '0;
				count_q <= '0;
				done_q  <= 1'b0;
			end else if (!done_q) begin
				window_q <= window_nx;
				count_q  <= count_nx;
				done_q   <= hit;
			end
		end
	end

	assign step.emit  = !done_q && (hit || item.last_byte);
	assign step.found = hit;
	assign step.len   = len_eff;
	assign step.count = count_nx;

endmodule

FILE: design/bps_result.sv
// ----------------------------------------------------------------------------
// bps_result: result address math and output register
// Forms match addresses and holds the result word until the sink takes it.
// ----------------------------------------------------------------------------
module bps_result (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  bps_pkg::step_t     step,
	input  bps_pkg::cfg_t      cfg,
	input  logic               out_ready,
	output logic               out_valid,
	output bps_pkg::out_item_t out_item,
	output logic               in_ready
);
	import bps_pkg::*;

	logic              run_q;
	logic              valid_q;
	out_item_t         item_q;
	logic [ADDR_W-1:0] end_addr;
	logic [ADDR_W-1:0] start_addr;

	assign end_addr   = cfg.range_start + step.count;
	assign start_addr = end_addr - ADDR_W'(step.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
			if (accept && step.emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && step.emit) begin
			item_q.found       <= step.found;
			item_q.match_start <= step.found ? start_addr : cfg.range_start;
			item_q.match_end   <= step.found ? end_addr : cfg.range_start;
		end
	end

	assign in_ready  = run_q && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

FILE: design/bps_checker.sv
// ----------------------------------------------------------------------------
// bps_checker: port-level checks for byte_pattern_search
// Watches the stream and result channels; attached to the top by bind.
// ----------------------------------------------------------------------------
module bps_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         found,
	input logic [bps_pkg::ADDR_W-1:0]   match_start,
	input logic [bps_pkg::ADDR_W-1:0]   match_end
);
	import bps_pkg::*;

	logic [ADDR_W-1:0] span;
	assign span = match_end - match_start;

	// result word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) &&
			$stable(match_start) && $stable(match_end))
		else $error("result word changed while stalled");

	// not found: empty range
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_start == match_end)
		else $error("not-found word with non-empty range");

	// found: span is the pattern length, 1..MAX_PATTERN
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> span != '0 && span <= ADDR_W'(MAX_PATTERN))
		else $error("match span out of range");

	// every new result word comes from a byte taken the cycle before
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!$past(out_valid) || $past(out_ready)) |->
			$past(in_valid && in_ready))
		else $error("result word without an accepted byte");

endmodule

bind byte_pattern_search bps_checker u_bps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (stream.valid),
	.in_ready    (stream.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.found       (result.payload.found),
	.match_start (result.payload.match_start),
	.match_end   (result.payload.match_end)
);

FILE: tb/sv/bps_search_checker.sv
// ----------------------------------------------------------------------------
// bps_search_checker: scoreboard for the byte pattern search
// Follows the register port and both word channels, keeps its own window,
// byte count and match flag, predicts the result word of each range and
// compares every accepted result word field by field in order.
// ----------------------------------------------------------------------------
module bps_search_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	input  logic                           byte_ready,
	input  bps_pkg::in_item_t              byte_word,
	input  logic                           res_valid,
	input  logic                           res_ready,
	input  bps_pkg::out_item_t             res_word,
	input  logic                           wr_en,
	input  bps_pkg::cfg_index_t            wr_index,
	input  logic [bps_pkg::CFG_DATA_W-1:0] wr_data,
	output int                             pending,
	output int                             fails
);
	import bps_pkg::*;

	logic [LEN_W-1:0]  pat_len;
	logic [127:0]      pat_bytes;
	logic [ADDR_W-1:0] base_addr;

	logic [7:0]        window [MAX_PATTERN];
	logic [ADDR_W-1:0] seen;
	logic              matched;

	out_item_t         expected_words [$];
	int                bad_words;

	task automatic clear_window();
		for (int k = 0; k < MAX_PATTERN; k++) window[k] = 8'h00;
		seen    = '0;
		matched = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int unsigned       eff_len;
		logic              hit;
		logic [ADDR_W-1:0] stop;
		out_item_t         want;
		if (!arst_n) begin
			pat_len   = '0;
			pat_bytes = '0;
			base_addr = '0;
			clear_window();
			expected_words.delete();
			bad_words = 0;
			pending <= 0;
			fails   <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_PATTERN_LENGTH: pat_len = wr_data[LEN_W-1:0];
					REG_PATTERN_LOW:    pat_bytes[63:0] = wr_data;
					REG_PATTERN_HIGH:   pat_bytes[127:64] = wr_data;
					REG_RANGE_START:    base_addr = wr_data[ADDR_W-1:0];
					default: ;
				endcase
			end

			if (res_valid && res_ready) begin
				if (expected_words.size() == 0) begin
					if (bad_words < 10)
						$display("bps_search_checker: unexpected word found=%0d start=%h end=%h",
							res_word.found, res_word.match_start, res_word.match_end);
					bad_words++;
				end else begin
					want = expected_words.pop_front();
					if (res_word.found !== want.found ||
						res_word.match_start !== want.match_start ||
						res_word.match_end !== want.match_end) begin
						if (bad_words < 10)
							$display("bps_search_checker: expected %0d %h %h, got %0d %h %h",
								want.found, want.match_start, want.match_end,
								res_word.found, res_word.match_start, res_word.match_end);
						bad_words++;
					end
				end
			end

			if (byte_valid && byte_ready) begin
				eff_len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
				if (!matched) begin
					for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
					window[0] = byte_word.data_byte;
					seen = seen + 1'b1;
					hit = (eff_len > 0) && (seen >= eff_len);
					for (int k = 0; k < eff_len; k++)
						if (window[eff_len-1-k] != pat_bytes[8*k +: 8]) hit = 1'b0;
					if (hit) begin
						stop = base_addr + seen;
						expected_words.push_back(out_item_t'{found: 1'b1,
							match_start: stop - eff_len, match_end: stop});
						matched = 1'b1;
					end else if (byte_word.last_byte) begin
						expected_words.push_back(out_item_t'{found: 1'b0,
							match_start: base_addr, match_end: base_addr});
					end
				end
				if (byte_word.last_byte) clear_window();
			end

			pending <= expected_words.size();
			fails   <= bad_words;
		end
	end

endmodule

FILE: tb/sv/tb_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// tb_byte_pattern_search: testbench top for the byte pattern search
// Drives directed ranges (empty and overlong patterns, address wrap, match on
// the last byte, bytes after a match, short ranges), then random ranges with
// planted patterns under changing settings and idle/stall mixes. The checker
// beside the block predicts and compares; the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_byte_pattern_search;
	import bps_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	cfg_index_t            wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	bps_stream_if #(.payload_t(in_item_t))  stream_ch ();
	bps_stream_if #(.payload_t(out_item_t)) result_ch ();

	int pending;
	int fails;
	int send_idle_pct;
	int stall_pct;
	int words_sent;

	logic [LEN_W-1:0] cur_len;
	logic [127:0]     cur_pattern;
	logic [7:0]       range_bytes [$];

	byte_pattern_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	bps_search_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (stream_ch.valid),
		.byte_ready (stream_ch.ready),
		.byte_word  (stream_ch.payload),
		.res_valid  (result_ch.valid),
		.res_ready  (result_ch.ready),
		.res_word   (result_ch.payload),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.pending    (pending),
		.fails      (fails)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("tb_byte_pattern_search: done, errors");
		$finish;
	end

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// unused upper bits of the narrow registers get random junk
	task automatic write_cfg(input logic [LEN_W-1:0] len, input logic [63:0] lo,
		input logic [63:0] hi, input logic [ADDR_W-1:0] start);
		logic [63:0] junk;
		junk = {$urandom(), $urandom()};
		wr_en    <= 1'b1;
		wr_index <= REG_PATTERN_LENGTH;
		wr_data  <= {junk[63:LEN_W], len};
		@(posedge clk);
		wr_index <= REG_PATTERN_LOW;
		wr_data  <= lo;
		@(posedge clk);
		wr_index <= REG_PATTERN_HIGH;
		wr_data  <= hi;
		@(posedge clk);
		wr_index <= REG_RANGE_START;
		wr_data  <= {junk[63:ADDR_W], start};
		@(posedge clk);
		wr_en <= 1'b0;
		cur_len     = len;
		cur_pattern = {hi, lo};
	endtask

	task automatic send_range();
		for (int i = 0; i < range_bytes.size(); i++) begin
			while ($urandom_range(0, 99) < send_idle_pct) begin
				stream_ch.valid <= 1'b0;
				@(posedge clk);
			end
			stream_ch.valid   <= 1'b1;
			stream_ch.payload <= in_item_t'{data_byte: range_bytes[i],
				last_byte: (i == range_bytes.size() - 1)};
			@(posedge clk);
			while (!stream_ch.ready) @(posedge clk);
			words_sent++;
		end
	endtask

	task automatic settle();
		stream_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int               n;
		int               eff;
		int               pos;
		int               seg;
		int               r;
		logic [LEN_W-1:0] len;
		logic [ADDR_W-1:0] start;

		arst_n            = 1'b0;
		wr_en             = 1'b0;
		wr_index          = REG_PATTERN_LENGTH;
		wr_data           = '0;
		stream_ch.valid   = 1'b0;
		stream_ch.payload = '0;
		result_ch.ready   = 1'b0;
		send_idle_pct     = 0;
		stall_pct         = 0;
		words_sent        = 0;
		cur_len           = '0;
		cur_pattern       = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern: not found at the last byte
		write_cfg(5'd0, 64'h0, 64'h0, 32'h0000_0000);
		range_bytes = {8'h00, 8'hFF};
		send_range();
		settle();

		// one-byte range, match on the last byte, end address wraps
		write_cfg(5'd1, 64'h0000_0000_0000_00FF, 64'h0, 32'hFFFF_FFFF);
		range_bytes = {8'hFF};
		send_range();
		settle();

		// overlong length clamps to the full window, match on the last byte
		write_cfg(5'd31, 64'h80FF_7F01_00A5_5A3C, 64'hC3E1_F00F_1E87_FF00, 32'h1234_5678);
		range_bytes = {};
		for (int k = 0; k < MAX_PATTERN; k++) range_bytes.push_back(cur_pattern[8*k +: 8]);
		send_range();
		settle();

		// bytes after a match are ignored
		write_cfg(5'd3, 64'h0000_0000_0000_55AA, 64'h0, 32'h8000_0000);
		range_bytes = {8'h13, 8'hAA, 8'h55, 8'h00, 8'h22, 8'h33};
		send_range();
		settle();

		// range shorter than the pattern
		write_cfg(5'd2, 64'h0000_0000_0000_55AA, 64'h0, 32'h0000_0000);
		range_bytes = {8'hAA};
		send_range();
		settle();

		seg = 0;
		while (words_sent < 1025) begin
			case (seg % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 59; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 59; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase

			r = $urandom_range(0, 9);
			if (r == 0) len = 5'd0;
			else if (r == 1) len = 5'd16;
			else if (r == 2) len = 5'($urandom_range(17, 31));
			else if (r == 3) len = 5'($urandom_range(7, 15));
			else len = 5'($urandom_range(1, 4));
			r = $urandom_range(0, 5);
			if (r == 0) start = 32'h0000_0000;
			else if (r == 1) start = 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
			else start = $urandom();
			write_cfg(len, {$urandom(), $urandom()}, {$urandom(), $urandom()}, start);

			eff = (cur_len > MAX_PATTERN) ? MAX_PATTERN : cur_len;
			repeat ($urandom_range(3, 6)) begin
				n = $urandom_range(1, 30);
				range_bytes = {};
				for (int i = 0; i < n; i++) begin
					if (eff > 0 && $urandom_range(0, 2) == 0)
						range_bytes.push_back(cur_pattern[8*$urandom_range(0, eff - 1) +: 8]);
					else
						range_bytes.push_back(8'($urandom()));
				end
				if (eff > 0 && n >= eff && $urandom_range(0, 99) < 60) begin
					pos = $urandom_range(0, n - eff);
					for (int k = 0; k < eff; k++) range_bytes[pos+k] = cur_pattern[8*k +: 8];
				end
				send_range();
			end
			settle();
			seg++;
		end

		if (fails == 0 && pending == 0)
			$display("tb_byte_pattern_search: done, clean");
		else
			$display("tb_byte_pattern_search: done, errors");
		$finish;
	end

endmodule
